[rtl/rt2d_pkg.sv]
// Package for the planar rigid transform block: widths, fixed-point constants,
// register map, CORDIC state type, arctangent table and shared structs.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package rt2d_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 24;
   localparam int ANG_FRAC     = 24;
   localparam int ANG_SHIFT    = ANG_FRAC - FRAC_BITS;

   localparam int COORD_W = 32;
   localparam int ROT_W   = 25;
   localparam int TRIG_W  = 32;
   localparam int XY_W    = 34;
   localparam int Z_W     = 35;
   localparam int CNT_W   = $clog2(CORDIC_STEPS);
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam longint DEG90_L  = 64'sd90 <<< ANG_FRAC;
   localparam longint DEG180_L = 64'sd180 <<< ANG_FRAC;
   localparam longint DEG360_L = 64'sd360 <<< ANG_FRAC;

   localparam logic signed [Z_W-1:0]  DEG90    = Z_W'(DEG90_L);
   localparam logic signed [Z_W-1:0]  DEG180   = Z_W'(DEG180_L);
   localparam logic signed [Z_W-1:0]  DEG360   = Z_W'(DEG360_L);
   localparam logic signed [XY_W-1:0] GAIN_Q30 = XY_W'(64'sd652032874);
   localparam logic signed [XY_W-1:0] ONE_Q30  = XY_W'(64'sd1 <<< 30);

   // point direction codes
   localparam logic OP_TO_BASE = 1'b0;
   localparam logic OP_TO_TOOL = 1'b1;

   typedef enum logic [1:0] {
      REG_ROTATION    = 2'd0,
      REG_TRANSLATE_X = 2'd1,
      REG_TRANSLATE_Y = 2'd2
   } reg_index_type;

   typedef enum logic [4:0] {
      CS_WRAP   = 5'b00001,
      CS_FOLD   = 5'b00010,
      CS_ITER   = 5'b00100,
      CS_FINISH = 5'b01000,
      CS_DONE   = 5'b10000
   } cordic_state_type;

   typedef struct packed {
      logic                      start;
      logic signed [ROT_W-1:0]   rotation;
      logic signed [COORD_W-1:0] tx;
      logic signed [COORD_W-1:0] ty;
   } cfg_type;

   typedef struct packed {
      logic                     busy;
      logic signed [TRIG_W-1:0] cos_q30;
      logic signed [TRIG_W-1:0] sin_q30;
   } trig_type;

   // atan(2^-i) in degrees, 24 fraction bits
   function automatic logic [29:0] atan_q24(input logic [4:0] idx);
      logic [29:0] val;
      case (idx)
         5'd0:  val = 30'd754974720;
         5'd1:  val = 30'd445687602;
         5'd2:  val = 30'd235489088;
         5'd3:  val = 30'd119537938;
         5'd4:  val = 30'd60000934;
         5'd5:  val = 30'd30029717;
         5'd6:  val = 30'd15018523;
         5'd7:  val = 30'd7509720;
         5'd8:  val = 30'd3754917;
         5'd9:  val = 30'd1877466;
         5'd10: val = 30'd938734;
         5'd11: val = 30'd469367;
         5'd12: val = 30'd234684;
         5'd13: val = 30'd117342;
         5'd14: val = 30'd58671;
         5'd15: val = 30'd29335;
         5'd16: val = 30'd14668;
         5'd17: val = 30'd7334;
         5'd18: val = 30'd3667;
         5'd19: val = 30'd1833;
         5'd20: val = 30'd917;
         5'd21: val = 30'd458;
         5'd22: val = 30'd229;
         5'd23: val = 30'd115;
         5'd24: val = 30'd57;
         5'd25: val = 30'd29;
         5'd26: val = 30'd14;
         5'd27: val = 30'd7;
         5'd28: val = 30'd4;
         5'd29: val = 30'd2;
         5'd30: val = 30'd1;
         default: val = 30'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

[rtl/rt2d_if.sv]
// Stream channel interfaces: point beats in, transformed point beats out.
// Depends on rt2d_pkg for field widths.
`default_nettype none

interface rt2d_req_if;
   logic                                       valid;
   logic                                       ready;
   logic                                       op;
   logic signed [rt2d_pkg::COORD_W-1:0]        x_in;
   logic signed [rt2d_pkg::COORD_W-1:0]        y_in;

   modport source (output valid, output op, output x_in, output y_in, input ready);
   modport sink   (input valid, input op, input x_in, input y_in, output ready);
endinterface

interface rt2d_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [rt2d_pkg::COORD_W-1:0]        x_out;
   logic signed [rt2d_pkg::COORD_W-1:0]        y_out;
   logic                                       saturated;

   modport source (output valid, output x_out, output y_out, output saturated,
                   input ready);
   modport sink   (input valid, input x_out, input y_out, input saturated,
                   output ready);
endinterface

`default_nettype wire

[rtl/rt2d_csr.sv]
// APB-style register file: rotation angle and translation.
// Depends on rt2d_pkg; pulses start on every rotation write.
`default_nettype none

module rt2d_csr (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            psel,
   input  wire                            penable,
   input  wire                            pwrite,
   input  wire [rt2d_pkg::ADDR_W-1:0]     paddr,
   input  wire [rt2d_pkg::DATA_W-1:0]     pwdata,
   output logic [rt2d_pkg::DATA_W-1:0]    prdata,
   output logic                           pready,
   output rt2d_pkg::cfg_type              cfg
);

   logic signed [rt2d_pkg::ROT_W-1:0]   rotation_ff;
   logic signed [rt2d_pkg::COORD_W-1:0] tx_ff;
   logic signed [rt2d_pkg::COORD_W-1:0] ty_ff;
   logic                                wr_en;
   rt2d_pkg::reg_index_type             reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = rt2d_pkg::reg_index_type'(paddr[rt2d_pkg::ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff <= '0;
         tx_ff       <= '0;
         ty_ff       <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            rt2d_pkg::REG_ROTATION:    rotation_ff <= pwdata[rt2d_pkg::ROT_W-1:0];
            rt2d_pkg::REG_TRANSLATE_X: tx_ff       <= pwdata;
            rt2d_pkg::REG_TRANSLATE_Y: ty_ff       <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         rt2d_pkg::REG_ROTATION:
            prdata = rt2d_pkg::DATA_W'(rotation_ff);
         rt2d_pkg::REG_TRANSLATE_X: prdata = tx_ff;
         rt2d_pkg::REG_TRANSLATE_Y: prdata = ty_ff;
         default:                   prdata = '0;
      endcase
   end

   always_comb begin
      cfg.start    = wr_en && (reg_idx == rt2d_pkg::REG_ROTATION);
      cfg.rotation = rotation_ff;
      cfg.tx       = tx_ff;
      cfg.ty       = ty_ff;
   end

endmodule

`default_nettype wire

[rtl/rt2d_cordic.sv]
// Iterative rotation-mode CORDIC in degrees: one micro-rotation per cycle,
// produces Q2.30 cosine and sine of the configured angle. Depends on rt2d_pkg.
`default_nettype none

module rt2d_cordic (
   input  wire                          clock,
   input  wire                          reset,
   input  rt2d_pkg::cfg_type            cfg,
   output rt2d_pkg::trig_type           trig
);

   rt2d_pkg::cordic_state_type             state_ff, state_in;
   logic signed [rt2d_pkg::XY_W-1:0]       x_ff, x_in;
   logic signed [rt2d_pkg::XY_W-1:0]       y_ff, y_in;
   logic signed [rt2d_pkg::Z_W-1:0]        z_ff, z_in;
   logic [rt2d_pkg::CNT_W-1:0]             cnt_ff, cnt_in;
   logic                                   flip_ff, flip_in;
   logic signed [rt2d_pkg::TRIG_W-1:0]     cos_ff, cos_in;
   logic signed [rt2d_pkg::TRIG_W-1:0]     sin_ff, sin_in;

   logic signed [rt2d_pkg::Z_W-1:0]        z_ang;
   logic signed [rt2d_pkg::XY_W-1:0]       xs, ys, xn, yn;
   logic signed [rt2d_pkg::Z_W-1:0]        atan_z;

   assign z_ang  = rt2d_pkg::Z_W'(cfg.rotation) <<< rt2d_pkg::ANG_SHIFT;
   assign xs     = x_ff >>> cnt_ff;
   assign ys     = y_ff >>> cnt_ff;
   assign atan_z = $signed({{(rt2d_pkg::Z_W-30){1'b0}}, rt2d_pkg::atan_q24(5'(cnt_ff))});
   assign xn     = flip_ff ? -x_ff : x_ff;
   assign yn     = flip_ff ? -y_ff : y_ff;

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      cnt_in   = cnt_ff;
      flip_in  = flip_ff;
      cos_in   = cos_ff;
      sin_in   = sin_ff;
      unique case (state_ff)
         rt2d_pkg::CS_WRAP: begin
            // bring the angle into [-180, 180)
            if (z_ang >= rt2d_pkg::DEG180) begin
               z_in = z_ang - rt2d_pkg::DEG360;
            end else if (z_ang < -rt2d_pkg::DEG180) begin
               z_in = z_ang + rt2d_pkg::DEG360;
            end else begin
               z_in = z_ang;
            end
            x_in     = rt2d_pkg::GAIN_Q30;
            y_in     = '0;
            cnt_in   = '0;
            flip_in  = 1'b0;
            state_in = rt2d_pkg::CS_FOLD;
         end
         rt2d_pkg::CS_FOLD: begin
            // fold beyond +-90 by a half turn; negate at the end
            if (z_ff > rt2d_pkg::DEG90) begin
               z_in    = z_ff - rt2d_pkg::DEG180;
               flip_in = 1'b1;
            end else if (z_ff < -rt2d_pkg::DEG90) begin
               z_in    = z_ff + rt2d_pkg::DEG180;
               flip_in = 1'b1;
            end
            state_in = rt2d_pkg::CS_ITER;
         end
         rt2d_pkg::CS_ITER: begin
            if (!z_ff[rt2d_pkg::Z_W-1]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_z;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_z;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == rt2d_pkg::CNT_W'(rt2d_pkg::CORDIC_STEPS - 1)) begin
               state_in = rt2d_pkg::CS_FINISH;
            end
         end
         rt2d_pkg::CS_FINISH: begin
            if (xn > rt2d_pkg::ONE_Q30) begin
               cos_in = rt2d_pkg::TRIG_W'(rt2d_pkg::ONE_Q30);
            end else if (xn < -rt2d_pkg::ONE_Q30) begin
               cos_in = rt2d_pkg::TRIG_W'(-rt2d_pkg::ONE_Q30);
            end else begin
               cos_in = rt2d_pkg::TRIG_W'(xn);
            end
            if (yn > rt2d_pkg::ONE_Q30) begin
               sin_in = rt2d_pkg::TRIG_W'(rt2d_pkg::ONE_Q30);
            end else if (yn < -rt2d_pkg::ONE_Q30) begin
               sin_in = rt2d_pkg::TRIG_W'(-rt2d_pkg::ONE_Q30);
            end else begin
               sin_in = rt2d_pkg::TRIG_W'(yn);
            end
            state_in = rt2d_pkg::CS_DONE;
         end
         rt2d_pkg::CS_DONE: ;
         default: state_in = rt2d_pkg::CS_WRAP;
      endcase
      // a new angle restarts the sweep from any state
      if (cfg.start) begin
         state_in = rt2d_pkg::CS_WRAP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rt2d_pkg::CS_WRAP;
      end else begin
         state_ff <= state_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      cnt_ff  <= cnt_in;
      flip_ff <= flip_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   always_comb begin
      trig.busy    = (state_ff != rt2d_pkg::CS_DONE);
      trig.cos_q30 = cos_ff;
      trig.sin_q30 = sin_ff;
   end

endmodule

`default_nettype wire

[rtl/rt2d_datapath.sv]
// Four-stage point pipeline: pre-subtract, multiply, sum and round,
// translate and saturate. Depends on rt2d_pkg and the channel interfaces.
`default_nettype none

module rt2d_datapath (
   input  wire                  clock,
   input  wire                  reset,
   input  rt2d_pkg::cfg_type    cfg,
   input  rt2d_pkg::trig_type   trig,
   rt2d_req_if.sink             req_ch,
   rt2d_rsp_if.source           rsp_ch
);

   localparam int OPND_W = rt2d_pkg::COORD_W + 1;
   localparam int PROD_W = rt2d_pkg::TRIG_W + OPND_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int RND_W  = SUM_W - 30;
   localparam int OUT_W  = RND_W + 1;

   localparam logic signed [OUT_W-1:0] SAT_MAX = OUT_W'(64'sd2147483647);
   localparam logic signed [OUT_W-1:0] SAT_MIN = OUT_W'(-64'sd2147483648);
   localparam logic signed [SUM_W-1:0] HALF    = SUM_W'(64'sd1 <<< 29);

   logic en1, en2, en3, en4, accept;

   logic                        v1_ff, v2_ff, v3_ff, v4_ff;
   logic                        op1_ff, op2_ff, op3_ff;
   logic signed [OPND_W-1:0]    a1_ff, b1_ff, a1_in, b1_in;
   logic signed [PROD_W-1:0]    ca_ff, sb_ff, sa_ff, cb_ff;
   logic signed [RND_W-1:0]     rx_ff, ry_ff;
   logic signed [SUM_W-1:0]     sx, sy, sxh, syh;
   logic signed [OUT_W-1:0]     fx, fy;
   logic signed [rt2d_pkg::COORD_W-1:0] xo_ff, yo_ff, xo_in, yo_in;
   logic                        sat_ff, sat_in;

   // each stage advances when empty or when the next one advances
   assign en4    = !v4_ff || rsp_ch.ready;
   assign en3    = !v3_ff || en4;
   assign en2    = !v2_ff || en3;
   assign en1    = !v1_ff || en2;
   assign req_ch.ready = en1 && !trig.busy;
   assign accept = req_ch.valid && req_ch.ready;

   // stage 1: take the point; base to tool removes the translation first
   always_comb begin
      if (req_ch.op == rt2d_pkg::OP_TO_TOOL) begin
         a1_in = OPND_W'(req_ch.x_in) - OPND_W'(cfg.tx);
         b1_in = OPND_W'(req_ch.y_in) - OPND_W'(cfg.ty);
      end else begin
         a1_in = OPND_W'(req_ch.x_in);
         b1_in = OPND_W'(req_ch.y_in);
      end
   end

   // stage 3: combine products and round half up
   always_comb begin
      if (op2_ff == rt2d_pkg::OP_TO_TOOL) begin
         sx = SUM_W'(ca_ff) + SUM_W'(sb_ff);
         sy = SUM_W'(cb_ff) - SUM_W'(sa_ff);
      end else begin
         sx = SUM_W'(ca_ff) - SUM_W'(sb_ff);
         sy = SUM_W'(sa_ff) + SUM_W'(cb_ff);
      end
      sxh = sx + HALF;
      syh = sy + HALF;
   end

   // stage 4: tool to base adds the translation, then clip
   always_comb begin
      if (op3_ff == rt2d_pkg::OP_TO_TOOL) begin
         fx = OUT_W'(rx_ff);
         fy = OUT_W'(ry_ff);
      end else begin
         fx = OUT_W'(rx_ff) + OUT_W'(cfg.tx);
         fy = OUT_W'(ry_ff) + OUT_W'(cfg.ty);
      end
      sat_in = 1'b0;
      if (fx > SAT_MAX) begin
         xo_in  = rt2d_pkg::COORD_W'(SAT_MAX);
         sat_in = 1'b1;
      end else if (fx < SAT_MIN) begin
         xo_in  = rt2d_pkg::COORD_W'(SAT_MIN);
         sat_in = 1'b1;
      end else begin
         xo_in  = rt2d_pkg::COORD_W'(fx);
      end
      if (fy > SAT_MAX) begin
         yo_in  = rt2d_pkg::COORD_W'(SAT_MAX);
         sat_in = 1'b1;
      end else if (fy < SAT_MIN) begin
         yo_in  = rt2d_pkg::COORD_W'(SAT_MIN);
         sat_in = 1'b1;
      end else begin
         yo_in  = rt2d_pkg::COORD_W'(fy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= accept;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         op1_ff <= req_ch.op;
         a1_ff  <= a1_in;
         b1_ff  <= b1_in;
      end
      if (en2) begin
         op2_ff <= op1_ff;
         ca_ff  <= trig.cos_q30 * a1_ff;
         sb_ff  <= trig.sin_q30 * b1_ff;
         sa_ff  <= trig.sin_q30 * a1_ff;
         cb_ff  <= trig.cos_q30 * b1_ff;
      end
      if (en3) begin
         op3_ff <= op2_ff;
         rx_ff  <= sxh[SUM_W-1:30];
         ry_ff  <= syh[SUM_W-1:30];
      end
      if (en4) begin
         xo_ff  <= xo_in;
         yo_ff  <= yo_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_ch.valid     = v4_ff;
   assign rsp_ch.x_out     = xo_ff;
   assign rsp_ch.y_out     = yo_ff;
   assign rsp_ch.saturated = sat_ff;

endmodule

`default_nettype wire

[rtl/rigid_transform_2d_top.sv]
// Top level of the planar rigid transform: register file, CORDIC for the
// angle's cosine and sine, and the point pipeline. Depends on rt2d_pkg.
//
//   channel   direction  handshake        beat contents
//   req_ch    in         valid/ready      op, x_in, y_in
//   rsp_ch    out        valid/ready      x_out, y_out, saturated
//   APB       in         psel/penable     rotation_deg, translate_x, translate_y
//
// One point per cycle while rsp_ch is ready and the CORDIC is idle; each beat
// passes the pipeline stage registers into the output register. Cosine and sine
// are swept by one shared CORDIC stage, one micro-rotation a cycle: after reset
// and after each rotation write, req_ch.ready stays low until its sweep is done.
// Reset is synchronous and clears all valid bits and the CSR registers to zero.
// A stall on rsp_ch holds each stage in place; empty stages still fill.
`default_nettype none

module rigid_transform_2d_top (
   input  wire                           clock,
   input  wire                           reset,
   rt2d_req_if.sink                      req_ch,
   rt2d_rsp_if.source                    rsp_ch,
   input  wire                           psel,
   input  wire                           penable,
   input  wire                           pwrite,
   input  wire [rt2d_pkg::ADDR_W-1:0]    paddr,
   input  wire [rt2d_pkg::DATA_W-1:0]    pwdata,
   output logic [rt2d_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   rt2d_pkg::cfg_type  cfg;
   rt2d_pkg::trig_type trig;

   rt2d_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rt2d_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .trig  (trig)
   );

   rt2d_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .trig   (trig),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

[verif/tb_rigid_transform_2d_top.sv]
// Self-checking testbench for rigid_transform_2d_top: random and directed point beats
// checked against a built-in fixed-point predictor, with APB frame writes between phases.
// Depends on rt2d_pkg and the rt2d_req_if / rt2d_rsp_if interfaces.

module tb_rigid_transform_2d_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W      = rt2d_pkg::COORD_W;
   localparam int FRAC_BITS    = rt2d_pkg::FRAC_BITS;
   localparam int ROT_W        = rt2d_pkg::ROT_W;
   localparam int ADDR_W       = rt2d_pkg::ADDR_W;
   localparam int DATA_W       = rt2d_pkg::DATA_W;
   localparam int ANG_SHIFT    = rt2d_pkg::ANG_SHIFT;
   localparam int CORDIC_STEPS = rt2d_pkg::CORDIC_STEPS;

   typedef rt2d_pkg::reg_index_type reg_index_type;

   localparam int CLK_HALF       = 5;
   localparam int RESET_CYCLES   = 2;
   localparam int LONG_STALL     = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int PHASES         = 15;
   localparam int PHASE_POINTS   = 84;

   localparam logic OP_TO_BASE = rt2d_pkg::OP_TO_BASE;
   localparam logic OP_TO_TOOL = rt2d_pkg::OP_TO_TOOL;

   localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fffffff;
   localparam logic signed [COORD_W-1:0] C_MIN = 32'sh80000000;

   localparam int DEG_90   = 90 << FRAC_BITS;
   localparam int DEG_180  = 180 << FRAC_BITS;
   localparam int ROT_TOP  = (1 << (ROT_W - 1)) - 1;
   localparam int ROT_BOT  = -(1 << (ROT_W - 1));

   localparam longint Q24_90   = 64'sd90 <<< 24;
   localparam longint Q24_180  = 64'sd180 <<< 24;
   localparam longint Q24_360  = 64'sd360 <<< 24;
   localparam longint Q30_ONE  = 64'sd1 <<< 30;
   localparam longint Q30_GAIN = 64'sd652032874;
   localparam longint Q30_HALF = 64'sd1 <<< 29;

   typedef struct packed {
      logic                      op;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_beat_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x_out;
      logic signed [COORD_W-1:0] y_out;
      logic                      saturated;
   } point_result_type;

   logic clock = 1'b0;
   logic reset;

   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [DATA_W-1:0]   pwdata;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   rt2d_req_if req_if ();
   rt2d_rsp_if rsp_if ();

   rigid_transform_2d_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // atan(2^-i) in degrees, 24 fraction bits
   longint atan_deg [0:31] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
      58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
      14, 7, 4, 2, 1, 0
   };

   logic signed [ROT_W-1:0]   frame_rotation = '0;
   logic signed [COORD_W-1:0] frame_tx = '0;
   logic signed [COORD_W-1:0] frame_ty = '0;

   point_beat_type   pending_points[$];
   point_result_type predicted_points[$];

   int  send_idle_pct = 32;
   int  recv_idle_pct = 68;
   logic sender_hold = 1'b0;
   logic stall_kick = 1'b0;
   logic stall_seen = 1'b0;
   int  stall_left = 0;
   int  idle_cycles = 0;
   int  mismatch_count = 0;

   always #CLK_HALF clock = ~clock;

   function automatic void frame_trig(input logic signed [ROT_W-1:0] ang,
                                      output longint c, output longint s);
      longint z, x, y, xs, ys;
      bit flip;
      int i;
      z = longint'(ang) * (64'sd1 <<< ANG_SHIFT);
      flip = 1'b0;
      z = z % Q24_360;
      if (z >= Q24_180) z = z - Q24_360;
      if (z < -Q24_180) z = z + Q24_360;
      // fold into the right half plane, undo with a sign flip
      if (z > Q24_90) begin
         z = z - Q24_180;
         flip = 1'b1;
      end else if (z < -Q24_90) begin
         z = z + Q24_180;
         flip = 1'b1;
      end
      x = Q30_GAIN;
      y = 0;
      for (i = 0; i < CORDIC_STEPS && i < 32; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - atan_deg[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + atan_deg[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = (x > Q30_ONE) ? Q30_ONE : ((x < -Q30_ONE) ? -Q30_ONE : x);
      s = (y > Q30_ONE) ? Q30_ONE : ((y < -Q30_ONE) ? -Q30_ONE : y);
   endfunction

   function automatic logic signed [COORD_W-1:0] clip_coord(input longint v,
                                                            inout logic flag);
      if (v > 64'sd2147483647) begin
         flag = 1'b1;
         return C_MAX;
      end
      if (v < -64'sd2147483648) begin
         flag = 1'b1;
         return C_MIN;
      end
      return v[COORD_W-1:0];
   endfunction

   function automatic point_result_type transform_point(input point_beat_type p);
      longint c, s, px, py, tx, ty, dx, dy, rx, ry;
      point_result_type r;
      logic flag;
      frame_trig(frame_rotation, c, s);
      px = longint'(signed'(p.x));
      py = longint'(signed'(p.y));
      tx = longint'(frame_tx);
      ty = longint'(frame_ty);
      if (p.op == OP_TO_BASE) begin
         rx = ((c * px - s * py + Q30_HALF) >>> 30) + tx;
         ry = ((s * px + c * py + Q30_HALF) >>> 30) + ty;
      end else begin
         // translate back first, then the transposed rotation
         dx = px - tx;
         dy = py - ty;
         rx = (c * dx + s * dy + Q30_HALF) >>> 30;
         ry = (c * dy - s * dx + Q30_HALF) >>> 30;
      end
      flag = 1'b0;
      r.x_out = clip_coord(rx, flag);
      r.y_out = clip_coord(ry, flag);
      r.saturated = flag;
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_coord();
      case ($urandom_range(9))
         0: return C_MAX;
         1: return C_MIN;
         2: return '0;
         3, 4, 5: return int'($urandom_range(2097152)) - 1048576;
         default: return $urandom;
      endcase
   endfunction

   function automatic int rand_angle();
      case ($urandom_range(11))
         0: return DEG_180;
         1: return -DEG_180;
         2: return 0;
         3: return DEG_90;
         4: return -DEG_90;
         5: return ROT_TOP;
         6: return ROT_BOT;
         default: return int'($urandom_range(2 * DEG_180)) - DEG_180;
      endcase
   endfunction

   // Point driver: offer the head of the pending queue, hold it until taken.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predicted_points = {predicted_points,
                                transform_point(pending_points.pop_front())};
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_points.size() > 0 && !sender_hold &&
                $urandom_range(99) >= send_idle_pct) begin
               req_if.valid <= 1'b1;
               req_if.op    <= pending_points[0].op;
               req_if.x_in  <= pending_points[0].x;
               req_if.y_in  <= pending_points[0].y;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each beat with the oldest prediction, drive ready.
   always @(posedge clock) begin : result_monitor
      point_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (predicted_points.size() == 0) begin
               $error("result beat with no point outstanding");
               mismatch_count++;
            end else begin
               want = predicted_points.pop_front();
               if (rsp_if.x_out !== want.x_out) begin
                  $error("x_out: expected %0d, got %0d", want.x_out, rsp_if.x_out);
                  mismatch_count++;
               end
               if (rsp_if.y_out !== want.y_out) begin
                  $error("y_out: expected %0d, got %0d", want.y_out, rsp_if.y_out);
                  mismatch_count++;
               end
               if (rsp_if.saturated !== want.saturated) begin
                  $error("saturated: expected %0d, got %0d", want.saturated,
                         rsp_if.saturated);
                  mismatch_count++;
               end
            end
         end
         if (stall_kick != stall_seen) begin
            stall_seen   <= stall_kick;
            stall_left   <= LONG_STALL;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || psel || (req_if.valid && req_if.ready) ||
          (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("rigid_transform_2d_top test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic csr_write(input reg_index_type idx, input logic [DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(4 * int'(idx));
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         rt2d_pkg::REG_ROTATION:    frame_rotation = value[ROT_W-1:0];
         rt2d_pkg::REG_TRANSLATE_X: frame_tx = value;
         rt2d_pkg::REG_TRANSLATE_Y: frame_ty = value;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_points.size() > 0 || predicted_points.size() > 0)
         @(negedge clock);
   endtask

   // Write a new frame while nothing is in flight, return on a falling edge.
   task automatic set_frame(input int rot, input int tx, input int ty);
      wait_drained();
      csr_write(rt2d_pkg::REG_ROTATION, rot);
      csr_write(rt2d_pkg::REG_TRANSLATE_X, tx);
      csr_write(rt2d_pkg::REG_TRANSLATE_Y, ty);
      @(negedge clock);
   endtask

   task automatic push_point(input logic op, input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
      point_beat_type p;
      p.op = op;
      p.x  = x;
      p.y  = y;
      pending_points = {pending_points, p};
   endtask

   initial begin
      int ph, n;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.op      = OP_TO_BASE;
      req_if.x_in    = '0;
      req_if.y_in    = '0;
      rsp_if.ready   = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset frame: identity
      push_point(OP_TO_BASE, 0, 0);
      push_point(OP_TO_BASE, C_MAX, C_MAX);
      push_point(OP_TO_TOOL, C_MIN, C_MIN);
      push_point(OP_TO_TOOL, C_MAX, C_MIN);

      // quarter turn with extreme translation: saturation, 33-bit difference
      set_frame(DEG_90, C_MAX, C_MIN);
      push_point(OP_TO_BASE, C_MAX, C_MAX);
      push_point(OP_TO_TOOL, C_MIN, C_MAX);
      push_point(OP_TO_BASE, 1, -1);
      push_point(OP_TO_TOOL, 0, 0);

      // half turn: negating the most negative coordinate clips
      set_frame(DEG_180, -1, 1);
      push_point(OP_TO_BASE, C_MIN, C_MIN);
      push_point(OP_TO_TOOL, C_MAX, 0);
      push_point(OP_TO_BASE, 32'sh00010000, 0);

      set_frame(-DEG_180, 32'sh12345678, -32'sh1234);
      push_point(OP_TO_BASE, C_MIN, C_MAX);
      push_point(OP_TO_TOOL, 12345, -6789);
      push_point(OP_TO_TOOL, C_MIN, C_MIN);

      // just past a quarter turn either way: folded angle
      set_frame(DEG_90 + 1, 0, 0);
      push_point(OP_TO_BASE, 32'sh00010000, 32'sh00010000);
      push_point(OP_TO_TOOL, -32'sh00010000, 32'sh7fff);

      set_frame(-DEG_90 - 1, C_MIN, C_MAX);
      push_point(OP_TO_BASE, C_MAX, C_MIN);
      push_point(OP_TO_TOOL, C_MIN, C_MAX);

      // angles beyond a half turn wrap modulo a full turn
      set_frame(ROT_TOP, 0, 0);
      push_point(OP_TO_BASE, 32'sh00010000, 0);
      push_point(OP_TO_TOOL, 0, 32'sh00010000);

      set_frame(ROT_BOT, 5, -5);
      push_point(OP_TO_BASE, 100000, -100000);
      push_point(OP_TO_TOOL, C_MAX, C_MAX);

      set_frame(DEG_90 / 2, 0, 0);
      push_point(OP_TO_BASE, C_MAX, 0);
      push_point(OP_TO_TOOL, 0, C_MIN);

      for (ph = 0; ph < PHASES; ph++) begin
         set_frame(rand_angle(), rand_coord(), rand_coord());
         if (ph < 5) begin
            send_idle_pct = 32;
            recv_idle_pct = 68;
         end else if (ph < 10) begin
            send_idle_pct = 68;
            recv_idle_pct = 32;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (n = 0; n < PHASE_POINTS; n++)
            push_point(1'($urandom_range(1)), rand_coord(), rand_coord());
         // long receiver hold-off while the sender keeps offering
         if (ph == 10 || ph == 2)
            stall_kick = ~stall_kick;
         // sender pause mid-phase until every result is back
         if (ph == 7 || ph == 12) begin
            while (pending_points.size() > PHASE_POINTS / 2) @(negedge clock);
            sender_hold = 1'b1;
            while (predicted_points.size() > 0) @(negedge clock);
            sender_hold = 1'b0;
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("rigid_transform_2d_top test passed");
      end else begin
         $display("rigid_transform_2d_top test failed");
      end
      $finish;
   end

endmodule
